// File: rtl/s8bdz_pkg.sv
// types, selector tables and register codes for the simple-8b delta zigzag decoder
`default_nettype none
package s8bdz_pkg;

  typedef logic [3:0] sel_t;

  typedef struct packed {
    logic [31:0] value;
    logic [63:0] word_next;
  } step_t;

  localparam logic [1:0] CFG_ELEMENT_COUNT = 2'd0;
  localparam logic [1:0] CFG_RAW_BLOCK     = 2'd1;

  localparam sel_t SEL_RUN240 = 4'd0;
  localparam sel_t SEL_RUN120 = 4'd1;

  localparam int CfgDataWidth = 24;
  localparam int SelWidth     = 4;

  function automatic logic [5:0] width_of_sel(input sel_t sel);
    logic [5:0] w;
    case (sel)
      4'd0:    w = 6'd0;
      4'd1:    w = 6'd0;
      4'd2:    w = 6'd1;
      4'd3:    w = 6'd2;
      4'd4:    w = 6'd3;
      4'd5:    w = 6'd4;
      4'd6:    w = 6'd5;
      4'd7:    w = 6'd6;
      4'd8:    w = 6'd7;
      4'd9:    w = 6'd8;
      4'd10:   w = 6'd10;
      4'd11:   w = 6'd12;
      4'd12:   w = 6'd15;
      4'd13:   w = 6'd20;
      4'd14:   w = 6'd30;
      default: w = 6'd60;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] count_of_sel(input sel_t sel);
    logic [7:0] c;
    case (sel)
      4'd0:    c = 8'd240;
      4'd1:    c = 8'd120;
      4'd2:    c = 8'd60;
      4'd3:    c = 8'd30;
      4'd4:    c = 8'd20;
      4'd5:    c = 8'd15;
      4'd6:    c = 8'd12;
      4'd7:    c = 8'd10;
      4'd8:    c = 8'd8;
      4'd9:    c = 8'd7;
      4'd10:   c = 8'd6;
      4'd11:   c = 8'd5;
      4'd12:   c = 8'd4;
      4'd13:   c = 8'd3;
      4'd14:   c = 8'd2;
      default: c = 8'd1;
    endcase
    return c;
  endfunction

  function automatic logic [63:0] field_mask(input sel_t sel);
    logic [63:0] m;
    m = (64'd1 << width_of_sel(sel)) - 64'd1;
    return m;
  endfunction

endpackage
`default_nettype wire

// File: rtl/simple8b_delta_zigzag_decoder.sv
// simple-8b delta zigzag decoder top level
// the request is registered into word_r, then each result into oval_r
// throughput: one result per cycle from the shared field unit unless
//   out_stall holds it; a new word is taken only when the last is done
// reset: synchronous active-low rst_n clears control, running value and count
`default_nettype none
module simple8b_delta_zigzag_decoder #(
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [23:0]          cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [63:0]          in_packed_word,
  input  wire logic                 in_block_start,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [31:0]        out_value,
  output logic [7:0]                out_repeat_count,
  output logic                      out_last_of_word,
  output logic                      out_block_done
);
  import s8bdz_pkg::*;

  localparam int ExtW = (COUNT_WIDTH > CfgDataWidth) ? COUNT_WIDTH : CfgDataWidth;

  logic                   busy_r, busy_nxt;
  logic [63:0]            word_r, word_nxt;
  sel_t                   sel_r, sel_nxt;
  logic [5:0]             left_r, left_nxt;
  logic [31:0]            running_r, running_nxt;
  logic [COUNT_WIDTH-1:0] produced_r, produced_nxt;
  logic [23:0]            ec_r;
  logic                   raw_r;

  logic                   ovalid_r, ovalid_nxt;
  logic [31:0]            oval_r, oval_nxt;
  logic [7:0]             orep_r, orep_nxt;
  logic                   olast_r, olast_nxt;
  logic                   odone_r, odone_nxt;

  logic [ExtW-1:0]        ec_ext;
  logic [COUNT_WIDTH-1:0] limit;
  logic [COUNT_WIDTH-1:0] remaining;
  logic [COUNT_WIDTH-1:0] prod_step;
  logic [7:0]             cnt;
  logic [7:0]             rep;
  logic                   is_run;
  logic                   slot_free;
  logic                   emit;
  logic                   done;
  logic                   last;
  logic                   accept;
  step_t                  res;

  s8bdz_step u_step (
    .word    (word_r),
    .sel     (sel_r),
    .raw     (raw_r),
    .running (running_r),
    .res     (res)
  );

  assign ec_ext    = ExtW'(ec_r);
  assign limit     = ec_ext[COUNT_WIDTH-1:0];
  assign remaining = limit - produced_r;
  assign cnt       = count_of_sel(sel_r);
  assign is_run    = !raw_r && (sel_r == SEL_RUN240 || sel_r == SEL_RUN120);
  assign rep       = !is_run ? 8'd1 :
                     (remaining < COUNT_WIDTH'(cnt)) ? remaining[7:0] : cnt;
  assign prod_step = produced_r + COUNT_WIDTH'(rep);
  assign done      = (prod_step == limit);
  assign last      = is_run || done || (left_r == 6'd1);
  assign slot_free = !ovalid_r || !out_stall;
  assign emit      = busy_r && slot_free && (produced_r < limit);
  assign in_stall  = busy_r;
  assign accept    = in_valid && !busy_r;

  always_comb begin
    busy_nxt     = busy_r;
    word_nxt     = word_r;
    sel_nxt      = sel_r;
    left_nxt     = left_r;
    running_nxt  = running_r;
    produced_nxt = produced_r;
    ovalid_nxt   = ovalid_r;
    oval_nxt     = oval_r;
    orep_nxt     = orep_r;
    olast_nxt    = olast_r;
    odone_nxt    = odone_r;
    if (slot_free) begin
      ovalid_nxt = 1'b0;
    end
    if (accept) begin
      busy_nxt = 1'b1;
      sel_nxt  = in_packed_word[3:0];
      word_nxt = raw_r ? in_packed_word : {4'd0, in_packed_word[63:4]};
      left_nxt = raw_r ? 6'd2 : 6'(count_of_sel(in_packed_word[3:0]));
      if (in_block_start) begin
        running_nxt  = '0;
        produced_nxt = '0;
      end
    end else if (busy_r && slot_free) begin
      if (emit) begin
        ovalid_nxt   = 1'b1;
        oval_nxt     = res.value;
        orep_nxt     = rep;
        olast_nxt    = last;
        odone_nxt    = done;
        running_nxt  = raw_r ? running_r : res.value;
        produced_nxt = prod_step;
        word_nxt     = res.word_next;
        left_nxt     = left_r - 6'd1;
        busy_nxt     = !last;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      ovalid_r   <= 1'b0;
      running_r  <= '0;
      produced_r <= '0;
      ec_r       <= '0;
      raw_r      <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      ovalid_r   <= ovalid_nxt;
      running_r  <= running_nxt;
      produced_r <= produced_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ELEMENT_COUNT: ec_r  <= cfg_wdata;
          CFG_RAW_BLOCK:     raw_r <= cfg_wdata[0];
          default:           ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    sel_r   <= sel_nxt;
    left_r  <= left_nxt;
    oval_r  <= oval_nxt;
    orep_r  <= orep_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_value        = oval_r;
  assign out_repeat_count = orep_r;
  assign out_last_of_word = olast_r;
  assign out_block_done   = odone_r;

endmodule
`default_nettype wire

// File: rtl/s8bdz_step.sv
// shared field unit: zigzag field decode, running add and word shift; run hold; raw 32-bit pass-through
`default_nettype none
module s8bdz_step (
  input  wire logic [63:0]       word,
  input  wire s8bdz_pkg::sel_t   sel,
  input  wire logic              raw,
  input  wire logic [31:0]       running,
  output s8bdz_pkg::step_t       res
);
  import s8bdz_pkg::*;

  logic [32:0] mask;
  logic [32:0] zm;
  logic [31:0] delta;

  assign mask  = 33'(field_mask(sel));
  assign zm    = word[32:0] & mask;
  assign delta = zm[32:1] ^ {32{zm[0]}};

  always_comb begin
    if (raw) begin
      res.value     = word[31:0];
      res.word_next = {32'd0, word[63:32]};
    end else if (sel == SEL_RUN240 || sel == SEL_RUN120) begin
      res.value     = running;
      res.word_next = word;
    end else begin
      res.value     = running + delta;
      res.word_next = word >> width_of_sel(sel);
    end
  end

endmodule
`default_nettype wire

// File: rtl/s8bdz_checker.sv
// port-level checks for the simple-8b delta zigzag decoder
`default_nettype none
module s8bdz_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_value,
  input wire logic [7:0]  out_repeat_count,
  input wire logic        out_last_of_word,
  input wire logic        out_block_done
);

  // a taken request keeps the input side closed while its word is decoded
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_value)))
    else $error("stalled result changed");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_block_done) |-> out_last_of_word)
    else $error("block done without last of word");

  a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_repeat_count != 8'd0))
    else $error("zero repeat count");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind simple8b_delta_zigzag_decoder s8bdz_checker u_s8bdz_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_value        (out_value),
  .out_repeat_count (out_repeat_count),
  .out_last_of_word (out_last_of_word),
  .out_block_done   (out_block_done)
);
`default_nettype wire
